### src/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property under the block clock, off while in reset
`define CHK_HOLDS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// implication checked on the next edge
`define CHK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/bjts_pkg.sv
`timescale 1ns / 1ps
package bjts_pkg;

   localparam int CODE_BITS   = 8;
   localparam int TARGET_BITS = 32;
   localparam int OFFSET_BITS = 24;
   localparam int HDR_BITS    = 24;

   typedef enum logic [2:0] {
      PH_OPCODE,
      PH_SKIP,
      PH_STRING,
      PH_DOLLAR,
      PH_CALL,
      PH_TARGET
   } phase_type;

   // opcode values
   localparam logic [7:0] OP_TEXT_BASE  = 8'h81;
   localparam logic [7:0] OP_TEXT_SPAN  = 8'h7C;
   localparam logic [7:0] OP_GAP_BASE   = 8'hA0;
   localparam logic [7:0] OP_GAP_SPAN   = 8'h40;
   localparam logic [7:0] OP_LINE       = 8'h0A;
   localparam logic [7:0] OP_BANG       = 8'h21;
   localparam logic [7:0] OP_AT         = 8'h40;
   localparam logic [7:0] OP_QUOTE      = 8'h22;
   localparam logic [7:0] OP_DOLLAR     = 8'h24;
   localparam logic [7:0] OP_DOLLAR_EXT = 8'hFF;
   localparam logic [7:0] OP_BSLASH     = 8'h5C;
   localparam logic [7:0] OP_LOWER_A    = 8'h61;
   localparam logic [7:0] OP_CALL       = 8'h23;
   localparam logic [7:0] OP_OPEN       = 8'h28;
   localparam logic [7:0] OP_CLOSE      = 8'h29;
   localparam logic [7:0] OP_BRACE_OPEN = 8'h7B;
   localparam logic [7:0] OP_BRACE_CLS  = 8'h7D;

   // operand lengths
   localparam logic [2:0] LEN_ONE    = 3'd1;
   localparam logic [2:0] LEN_TWO    = 3'd2;
   localparam logic [2:0] LEN_DOLLAR = 3'd4;
   localparam logic [2:0] LEN_CALL   = 3'd7;
   localparam logic [2:0] LEN_TARGET = 3'd4;

   // call modes
   localparam logic [3:0] MODE_NONE       = 4'd0;
   localparam logic [3:0] MODE_CLOSE      = 4'd1;
   localparam logic [3:0] MODE_ALIAS      = 4'd2;
   localparam logic [3:0] MODE_BRACE_WAIT = 4'd4;
   localparam logic [3:0] MODE_BRACE      = 4'd5;
   localparam logic [3:0] MODE_FOLD       = 4'd5;
   localparam logic [15:0] MODE_LIMIT     = 16'd10;
   localparam logic [7:0] KIND_JUMP       = 8'd1;

   typedef struct packed {
      logic                 last_byte;
      logic [CODE_BITS-1:0] code_byte;
   } req_word_type;

   typedef struct packed {
      logic                   truncated;
      logic                   end_of_code;
      logic [OFFSET_BITS-1:0] target_offset;
      logic [TARGET_BITS-1:0] target_value;
      logic                   target_valid;
   } rsp_word_type;

endpackage

### src/bjts_in_reg.sv
`timescale 1ns / 1ps
module bjts_in_reg
   import bjts_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  req_word_type in_word,
   output logic         in_ready,
   input  logic         take,
   output logic         hold_valid,
   output req_word_type hold_word
);

   logic         valid_ff, valid_in;
   req_word_type word_ff, word_in;

   assign in_ready   = !valid_ff || take;
   assign hold_valid = valid_ff;
   assign hold_word  = word_ff;

   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      if (in_ready) begin
         valid_in = in_valid;
         if (in_valid) begin
            word_in = in_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

endmodule

### src/bjts_scan.sv
`timescale 1ns / 1ps
module bjts_scan
   import bjts_pkg::*;
#(
   parameter int POS_BITS   = 24,
   parameter int DEPTH_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         step_en,
   input  req_word_type word,
   output logic         res_valid,
   output rsp_word_type res_word
);

   phase_type             phase_ff, phase_in;
   logic [2:0]            left_ff, left_in;
   logic [DEPTH_BITS-1:0] depth_ff, depth_in;
   logic [3:0]            mode_ff, mode_in;
   logic [HDR_BITS-1:0]   hdr_ff, hdr_in;
   logic [TARGET_BITS-1:0] accum_ff, accum_in;
   logic [POS_BITS-1:0]   pos_ff, pos_in;
   logic [POS_BITS-1:0]   start_ff, start_in;

   logic [POS_BITS+OFFSET_BITS-1:0] start_ext;
   logic [7:0]            b;
   logic [7:0]            text_rel, gap_rel;
   logic [DEPTH_BITS-1:0] depth_dec;
   logic [2:0]            call_idx;
   logic [1:0]            tgt_idx;
   logic [7:0]            hdr_kind;
   logic [15:0]           hdr_mode;
   logic [3:0]            mode_fold;
   logic                  got;

   assign b         = word.code_byte;
   assign text_rel  = b - OP_TEXT_BASE;
   assign gap_rel   = b - OP_GAP_BASE;
   assign depth_dec = depth_ff - 1'b1;
   assign call_idx  = LEN_CALL - left_ff;
   assign tgt_idx   = 2'(LEN_TARGET - left_ff);
   assign start_ext = {{OFFSET_BITS{1'b0}}, start_ff};

   always_comb begin
      phase_in  = phase_ff;
      left_in   = left_ff;
      depth_in  = depth_ff;
      mode_in   = mode_ff;
      hdr_in    = hdr_ff;
      accum_in  = accum_ff;
      pos_in    = pos_ff;
      start_in  = start_ff;
      got       = 1'b0;
      hdr_kind  = '0;
      hdr_mode  = '0;
      mode_fold = '0;
      res_word  = '0;
      res_valid = 1'b0;
      if (step_en) begin
         case (phase_ff)
            PH_OPCODE: begin
               if (text_rel < OP_TEXT_SPAN && gap_rel >= OP_GAP_SPAN) begin
                  phase_in = PH_SKIP;
                  left_in  = LEN_ONE;
               end else if (b == OP_LINE || b == OP_BANG || b == OP_AT) begin
                  phase_in = PH_SKIP;
                  left_in  = LEN_TWO;
               end else if (b == OP_QUOTE) begin
                  phase_in = PH_STRING;
               end else if (b == OP_DOLLAR) begin
                  phase_in = PH_DOLLAR;
               end else if (b == OP_BSLASH || b == OP_LOWER_A) begin
                  phase_in = PH_SKIP;
                  left_in  = LEN_ONE;
               end else if (b == OP_CALL) begin
                  phase_in = PH_CALL;
                  left_in  = LEN_CALL;
                  hdr_in   = '0;
               end else if (b == OP_OPEN) begin
                  depth_in = depth_ff + 1'b1;
               end else if (b == OP_CLOSE) begin
                  depth_in = depth_dec;
                  if (depth_dec == '0 && (mode_ff == MODE_CLOSE || mode_ff == MODE_BRACE)) begin
                     if (mode_ff == MODE_CLOSE) begin
                        mode_in = MODE_NONE;
                     end
                     phase_in = PH_TARGET;
                     left_in  = LEN_TARGET;
                     accum_in = '0;
                     start_in = pos_ff + 1'b1;
                  end
               end else if (b == OP_BRACE_OPEN) begin
                  if (mode_ff == MODE_BRACE_WAIT) begin
                     mode_in = MODE_BRACE;
                  end
               end else if (b == OP_BRACE_CLS) begin
                  mode_in = MODE_NONE;
               end
            end
            PH_SKIP: begin
               left_in = left_ff - 3'd1;
               if (left_in == 3'd0) begin
                  phase_in = PH_OPCODE;
               end
            end
            PH_STRING: begin
               if (b == OP_QUOTE) begin
                  phase_in = PH_OPCODE;
               end
            end
            PH_DOLLAR: begin
               if (b == OP_DOLLAR_EXT) begin
                  phase_in = PH_SKIP;
                  left_in  = LEN_DOLLAR;
               end else begin
                  phase_in = PH_OPCODE;
               end
            end
            PH_CALL: begin
               case (call_idx)
                  3'd1:    hdr_in[7:0]   = hdr_ff[7:0] | b;
                  3'd2:    hdr_in[15:8]  = hdr_ff[15:8] | b;
                  3'd3:    hdr_in[23:16] = hdr_ff[23:16] | b;
                  default: hdr_in = hdr_ff;
               endcase
               left_in = left_ff - 3'd1;
               if (left_in == 3'd0) begin
                  hdr_kind = hdr_in[7:0];
                  hdr_mode = hdr_in[23:8];
                  depth_in = '0;
                  phase_in = PH_OPCODE;
                  if (hdr_kind == KIND_JUMP && hdr_mode < MODE_LIMIT) begin
                     mode_fold = hdr_mode[3:0];
                     if (mode_fold >= MODE_FOLD) begin
                        mode_fold = mode_fold - MODE_FOLD;
                     end
                     if (mode_fold == MODE_ALIAS) begin
                        mode_fold = MODE_CLOSE;
                     end
                     if (mode_fold == MODE_NONE) begin
                        mode_in  = MODE_NONE;
                        phase_in = PH_TARGET;
                        left_in  = LEN_TARGET;
                        accum_in = '0;
                        start_in = pos_ff + 1'b1;
                     end else begin
                        mode_in = mode_fold;
                     end
                  end else begin
                     mode_in = MODE_NONE;
                  end
               end
            end
            PH_TARGET: begin
               case (tgt_idx)
                  2'd0:    accum_in[7:0]   = accum_ff[7:0] | b;
                  2'd1:    accum_in[15:8]  = accum_ff[15:8] | b;
                  2'd2:    accum_in[23:16] = accum_ff[23:16] | b;
                  default: accum_in[31:24] = accum_ff[31:24] | b;
               endcase
               left_in = left_ff - 3'd1;
               if (left_in == 3'd0) begin
                  got      = 1'b1;
                  phase_in = PH_OPCODE;
               end
            end
            default: begin
               phase_in = PH_OPCODE;
               left_in  = 3'd0;
            end
         endcase
         pos_in = pos_ff + 1'b1;

         res_valid              = got || word.last_byte;
         res_word.target_valid  = got;
         res_word.target_value  = got ? accum_in : '0;
         res_word.target_offset = got ? start_ext[OFFSET_BITS-1:0] : '0;
         res_word.end_of_code   = word.last_byte;
         res_word.truncated     = word.last_byte && (phase_in != PH_OPCODE);

         // end of code: next byte opens a fresh stream
         if (word.last_byte) begin
            phase_in = PH_OPCODE;
            left_in  = 3'd0;
            depth_in = '0;
            mode_in  = MODE_NONE;
            hdr_in   = '0;
            accum_in = '0;
            pos_in   = '0;
            start_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_OPCODE;
         left_ff  <= 3'd0;
         depth_ff <= '0;
         mode_ff  <= MODE_NONE;
         hdr_ff   <= '0;
         accum_ff <= '0;
         pos_ff   <= '0;
         start_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
         depth_ff <= depth_in;
         mode_ff  <= mode_in;
         hdr_ff   <= hdr_in;
         accum_ff <= accum_in;
         pos_ff   <= pos_in;
         start_ff <= start_in;
      end
   end

endmodule

### src/bjts_out_reg.sv
`timescale 1ns / 1ps
module bjts_out_reg
   import bjts_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         res_valid,
   input  rsp_word_type res_word,
   output logic         advance,
   output logic         out_valid,
   output rsp_word_type out_word,
   input  logic         out_ready
);

   logic         valid_ff, valid_in;
   rsp_word_type word_ff, word_in;

   assign advance   = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_word  = word_ff;

   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      if (advance) begin
         valid_in = res_valid;
         if (res_valid) begin
            word_in = res_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

endmodule

### src/bytecode_jump_target_scanner.sv
`timescale 1ns / 1ps
// Scans a bytecode stream, one byte per word on the req side, and returns a
// word on the rsp side for each completed 32-bit jump target and for the
// byte marked by req_tlast. Sustained rate is one byte per clock while the
// rsp side is ready. The scan state updates combinationally between the
// input register and the result register, which drives the rsp side, so a
// byte's result is registered there as the byte leaves the input register.
// A stalled rsp side holds the pipeline after one result waits. The byte
// with req_tlast set closes the stream and the next byte starts again at
// offset 0. No start-up pass after reset.
module bytecode_jump_target_scanner
   import bjts_pkg::*;
#(
   parameter int POS_BITS   = 24,
   parameter int DEPTH_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // code_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // target_value, target_offset
   output logic [1:0]  rsp_tuser,   // target_valid, truncated
   output logic        rsp_tlast    // end_of_code
);

   req_word_type req_word, hold_word;
   rsp_word_type res_word, out_word;
   logic         hold_valid, advance, res_valid;

   assign req_word.code_byte = req_tdata;
   assign req_word.last_byte = req_tlast;

   bjts_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_word    (req_word),
      .in_ready   (req_tready),
      .take       (advance),
      .hold_valid (hold_valid),
      .hold_word  (hold_word)
   );

   bjts_scan #(
      .POS_BITS   (POS_BITS),
      .DEPTH_BITS (DEPTH_BITS)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .step_en   (hold_valid && advance),
      .word      (hold_word),
      .res_valid (res_valid),
      .res_word  (res_word)
   );

   bjts_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res_word  (res_word),
      .advance   (advance),
      .out_valid (rsp_tvalid),
      .out_word  (out_word),
      .out_ready (rsp_tready)
   );

   assign rsp_tdata = {out_word.target_offset, out_word.target_value};
   assign rsp_tuser = {out_word.truncated, out_word.target_valid};
   assign rsp_tlast = out_word.end_of_code;

endmodule

### src/bjts_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bjts_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   logic unused_req;
   assign unused_req = req_tvalid ^ req_tready ^ (^req_tdata) ^ req_tlast;

   `CHK_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "rsp word changed while stalled")
   `CHK_HOLDS(a_rsp_reason, !rsp_tvalid || rsp_tuser[0] || rsp_tlast, "rsp word without target or end")
   `CHK_HOLDS(a_no_target_zero, !(rsp_tvalid && !rsp_tuser[0]) || rsp_tdata == 56'd0, "target fields set without target")
   `CHK_HOLDS(a_trunc_at_end, !(rsp_tvalid && rsp_tuser[1]) || rsp_tlast, "truncation flagged before end")

endmodule

bind bytecode_jump_target_scanner bjts_checker u_checker (.*);
